// ===== design/ubf_pkg.sv =====
// ubf_pkg: shared types and constants for the uart byte fifo engine
// action and result kind codes, fsm states, the result struct
// no dependencies
`timescale 1ns / 1ps
package ubf_pkg;

  localparam int BYTE_W              = 8;
  localparam int RING_DEPTH_DEFAULT  = 128;
  localparam int DRAIN_BURST_DEFAULT = 16;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_TX_EMPTY = 2'd1,
    ACT_RX_BYTE  = 2'd2,
    ACT_TAKE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_RX_DATA = 2'd1,
    KIND_RX_SIG  = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DRAIN,
    ST_TAKE
  } state_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic               led;
    logic               dropped;
  } res_t;

endpackage

// ===== design/ubf_ring_mem.sv =====
// ubf_ring_mem: byte ring storage, one write port and one registered read port
// depends on ubf_pkg for the byte width
`timescale 1ns / 1ps
module ubf_ring_mem #(
  parameter int DEPTH  = ubf_pkg::RING_DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [ubf_pkg::BYTE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [ubf_pkg::BYTE_W-1:0] rd_data
);
  import ubf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/ubf_ctrl.sv =====
// ubf_ctrl: item sequencer, ring pointers and fill counts, drain burst counter
// drives both ring memories; depends on ubf_pkg
`timescale 1ns / 1ps
module ubf_ctrl #(
  parameter int RING_DEPTH  = ubf_pkg::RING_DEPTH_DEFAULT,
  parameter int DRAIN_BURST = ubf_pkg::DRAIN_BURST_DEFAULT,
  parameter int PTR_W       = $clog2(RING_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [ubf_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_first_of_write,
  input  logic                       in_holding_empty,
  input  logic                       out_free,
  output logic                       res_valid,
  output ubf_pkg::res_t              res,
  output logic                       tx_wr_en,
  output logic [PTR_W-1:0]           tx_wr_addr,
  output logic                       tx_rd_en,
  output logic [PTR_W-1:0]           tx_rd_addr,
  input  logic [ubf_pkg::BYTE_W-1:0] tx_rd_data,
  output logic                       rx_wr_en,
  output logic [PTR_W-1:0]           rx_wr_addr,
  output logic                       rx_rd_en,
  output logic [PTR_W-1:0]           rx_rd_addr,
  input  logic [ubf_pkg::BYTE_W-1:0] rx_rd_data,
  output logic [ubf_pkg::BYTE_W-1:0] wr_data
);
  import ubf_pkg::*;

  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CNT_W  = $clog2(DRAIN_BURST + 1);

  state_t            state_r, state_nxt;
  action_t           act_r;
  logic [BYTE_W-1:0] byte_r;
  logic              first_r;
  logic              hold_r;

  logic [PTR_W-1:0]  tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic [PTR_W-1:0]  rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [FILL_W-1:0] tx_fill_r, tx_fill_nxt, rx_fill_r, rx_fill_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              led_r, led_nxt;

  logic tx_full, rx_full, tx_empty, rx_empty;
  logic direct, needs_res, go, start_drain, start_take, drain_last;
  logic [PTR_W-1:0] tx_wp_inc, tx_rp_inc, rx_wp_inc, rx_rp_inc;

  assign tx_full  = (tx_fill_r == FILL_W'(RING_DEPTH));
  assign rx_full  = (rx_fill_r == FILL_W'(RING_DEPTH));
  assign tx_empty = (tx_fill_r == '0);
  assign rx_empty = (rx_fill_r == '0);

  assign tx_wp_inc = (tx_wp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : tx_wp_r + PTR_W'(1);
  assign tx_rp_inc = (tx_rp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : tx_rp_r + PTR_W'(1);
  assign rx_wp_inc = (rx_wp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rx_wp_r + PTR_W'(1);
  assign rx_rp_inc = (rx_rp_r == PTR_W'(RING_DEPTH - 1)) ? '0 : rx_rp_r + PTR_W'(1);

  assign direct      = (act_r == ACT_WRITE) && first_r && hold_r;
  assign start_drain = (act_r == ACT_TX_EMPTY) && hold_r && !tx_empty;
  assign start_take  = (act_r == ACT_TAKE) && !rx_empty;
  assign needs_res   = ((act_r == ACT_WRITE) && (direct || tx_full))
                     || (act_r == ACT_RX_BYTE)
                     || ((act_r == ACT_TAKE) && rx_empty);
  assign go          = !needs_res || out_free;
  // fill already counts the reads issued so far in this burst
  assign drain_last  = (cnt_r == CNT_W'(DRAIN_BURST)) || tx_empty;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (go) begin
          if (start_drain)     state_nxt = ST_DRAIN;
          else if (start_take) state_nxt = ST_TAKE;
          else                 state_nxt = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (out_free && drain_last) state_nxt = ST_IDLE;
      end
      ST_TAKE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_stall    = (state_r != ST_IDLE);
    res_valid   = 1'b0;
    res         = '{kind: KIND_NONE, data: '0, last: 1'b1, led: led_r, dropped: 1'b0};
    tx_wr_en    = 1'b0;
    rx_wr_en    = 1'b0;
    tx_rd_en    = 1'b0;
    rx_rd_en    = 1'b0;
    tx_wp_nxt   = tx_wp_r;
    tx_rp_nxt   = tx_rp_r;
    rx_wp_nxt   = rx_wp_r;
    rx_rp_nxt   = rx_rp_r;
    tx_fill_nxt = tx_fill_r;
    rx_fill_nxt = rx_fill_r;
    cnt_nxt     = cnt_r;
    led_nxt     = led_r;
    case (state_r)
      ST_EXEC: begin
        if (go) begin
          case (act_r)
            ACT_WRITE: begin
              if (direct) begin
                res_valid = 1'b1;
                res.kind  = KIND_TX;
                res.data  = byte_r;
              end else if (tx_full) begin
                res_valid   = 1'b1;
                res.dropped = 1'b1;
              end else begin
                tx_wr_en    = 1'b1;
                tx_wp_nxt   = tx_wp_inc;
                tx_fill_nxt = tx_fill_r + FILL_W'(1);
              end
            end
            ACT_TX_EMPTY: begin
              if (start_drain) begin
                tx_rd_en    = 1'b1;
                tx_rp_nxt   = tx_rp_inc;
                tx_fill_nxt = tx_fill_r - FILL_W'(1);
                cnt_nxt     = CNT_W'(1);
              end
            end
            ACT_RX_BYTE: begin
              led_nxt     = !led_r;
              res_valid   = 1'b1;
              res.kind    = KIND_RX_SIG;
              res.led     = !led_r;
              res.dropped = rx_full;
              if (!rx_full) begin
                rx_wr_en    = 1'b1;
                rx_wp_nxt   = rx_wp_inc;
                rx_fill_nxt = rx_fill_r + FILL_W'(1);
              end
            end
            ACT_TAKE: begin
              if (start_take) begin
                rx_rd_en    = 1'b1;
                rx_rp_nxt   = rx_rp_inc;
                rx_fill_nxt = rx_fill_r - FILL_W'(1);
              end else begin
                res_valid = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          res_valid = 1'b1;
          res.kind  = KIND_TX;
          res.data  = tx_rd_data;
          res.last  = drain_last;
          // next read overlaps with handing over this byte
          if (!drain_last) begin
            tx_rd_en    = 1'b1;
            tx_rp_nxt   = tx_rp_inc;
            tx_fill_nxt = tx_fill_r - FILL_W'(1);
            cnt_nxt     = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_TAKE: begin
        if (out_free) begin
          res_valid = 1'b1;
          res.kind  = KIND_RX_DATA;
          res.data  = rx_rd_data;
        end
      end
      default: ;
    endcase
  end

  assign tx_wr_addr = tx_wp_r;
  assign tx_rd_addr = tx_rp_r;
  assign rx_wr_addr = rx_wp_r;
  assign rx_rd_addr = rx_rp_r;
  assign wr_data    = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tx_wp_r   <= '0;
      tx_rp_r   <= '0;
      rx_wp_r   <= '0;
      rx_rp_r   <= '0;
      tx_fill_r <= '0;
      rx_fill_r <= '0;
      cnt_r     <= '0;
      led_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tx_wp_r   <= tx_wp_nxt;
      tx_rp_r   <= tx_rp_nxt;
      rx_wp_r   <= rx_wp_nxt;
      rx_rp_r   <= rx_rp_nxt;
      tx_fill_r <= tx_fill_nxt;
      rx_fill_r <= rx_fill_nxt;
      cnt_r     <= cnt_nxt;
      led_r     <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      act_r   <= action_t'(in_action);
      byte_r  <= in_data_byte;
      first_r <= in_first_of_write;
      hold_r  <= in_holding_empty;
    end
  end

endmodule

// ===== design/uart_byte_fifo_engine.sv =====
// uart_byte_fifo_engine: top level, transmit and receive byte rings with output register
// instantiates ubf_ctrl and two ubf_ring_mem; depends on ubf_pkg
//
//   channel  | direction | handshake           | payload
//   in_      | input     | in_valid / in_stall | action, data_byte, first_of_write, holding_empty
//   out_     | output    | out_valid/out_stall | kind, out_byte, burst_last, activity_led, dropped
//
// one item at a time: a write, a received byte or an empty take passes idle and exec, a take
// that finds a byte also take (after the memory read), a drain of n bytes drain, one byte a cycle
// from the transmit ring read port while the output is not stalled.
// reset clears pointers, fill counts, led level and state; ring contents are not cleared.
// out_stall holds the result in the output register and pauses the sequencer.
`timescale 1ns / 1ps
module uart_byte_fifo_engine #(
  parameter int RING_DEPTH  = ubf_pkg::RING_DEPTH_DEFAULT,
  parameter int DRAIN_BURST = ubf_pkg::DRAIN_BURST_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_action,
  input  logic [ubf_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                       in_first_of_write,
  input  logic                       in_holding_empty,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_kind,
  output logic [ubf_pkg::BYTE_W-1:0] out_out_byte,
  output logic                       out_burst_last,
  output logic                       out_activity_led,
  output logic                       out_dropped
);
  import ubf_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic              out_valid_r;
  res_t              out_res_r;
  logic              out_free;
  logic              res_valid;
  res_t              res;

  logic              tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
  logic [PTR_W-1:0]  tx_wr_addr, tx_rd_addr, rx_wr_addr, rx_rd_addr;
  logic [BYTE_W-1:0] tx_rd_data, rx_rd_data, wr_data;

  assign out_free = !out_valid_r || !out_stall;

  ubf_ctrl #(
    .RING_DEPTH  (RING_DEPTH),
    .DRAIN_BURST (DRAIN_BURST),
    .PTR_W       (PTR_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_data_byte      (in_data_byte),
    .in_first_of_write (in_first_of_write),
    .in_holding_empty  (in_holding_empty),
    .out_free          (out_free),
    .res_valid         (res_valid),
    .res               (res),
    .tx_wr_en          (tx_wr_en),
    .tx_wr_addr        (tx_wr_addr),
    .tx_rd_en          (tx_rd_en),
    .tx_rd_addr        (tx_rd_addr),
    .tx_rd_data        (tx_rd_data),
    .rx_wr_en          (rx_wr_en),
    .rx_wr_addr        (rx_wr_addr),
    .rx_rd_en          (rx_rd_en),
    .rx_rd_addr        (rx_rd_addr),
    .rx_rd_data        (rx_rd_data),
    .wr_data           (wr_data)
  );

  ubf_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_tx_ring (
    .clk     (clk),
    .wr_en   (tx_wr_en),
    .wr_addr (tx_wr_addr),
    .wr_data (wr_data),
    .rd_en   (tx_rd_en),
    .rd_addr (tx_rd_addr),
    .rd_data (tx_rd_data)
  );

  ubf_ring_mem #(
    .DEPTH  (RING_DEPTH),
    .ADDR_W (PTR_W)
  ) u_rx_ring (
    .clk     (clk),
    .wr_en   (rx_wr_en),
    .wr_addr (rx_wr_addr),
    .wr_data (wr_data),
    .rd_en   (rx_rd_en),
    .rd_addr (rx_rd_addr),
    .rd_data (rx_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_res_r.kind;
  assign out_out_byte     = out_res_r.data;
  assign out_burst_last   = out_res_r.last;
  assign out_activity_led = out_res_r.led;
  assign out_dropped      = out_res_r.dropped;

  // a new result never overwrites one still held by a stalled output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || !out_stall))
    else $error("result pushed into a stalled output register");

  // an accepted item keeps the input side closed for the following cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in work");

  // only transmit drains end a result without the last mark
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res.kind != KIND_TX)) |-> res.last)
    else $error("non-drain result without last mark");

endmodule
